### src/tks_pkg.sv
package tks_pkg;

	localparam int MAX_KEPT = 8;
	localparam int NUM_KEYS = 4;
	localparam int KEY_W    = 32;
	localparam int ID_W     = 16;
	localparam int TOL_W    = 31;
	localparam int TAKE_W   = 4;
	localparam int NK_W     = 3;
	localparam int CNT_W    = $clog2(MAX_KEPT + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_KEYS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [ID_W-1:0] cand_id;
		key_t            score_a;
		key_t            score_b;
		key_t            score_c;
		key_t            score_d;
		logic            eligible;
		logic            final_cand;
	} cand_t;

	typedef struct packed {
		logic [ID_W-1:0] ranked_id;
		logic            none_kept;
		logic            run_end;
	} rank_t;

	typedef struct packed {
		key_t [NUM_KEYS-1:0] keys;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		logic                           load;
		logic                           none;
		logic [CNT_W-1:0]               cnt;
		logic [MAX_KEPT-1:0][ID_W-1:0]  ids;
	} drain_load_t;

endpackage

### src/tks_cell.sv
module tks_cell (
	input  logic                       clk,
	input  tks_pkg::entry_t            cand,
	input  tks_pkg::entry_t            prev,
	input  logic                       valid,
	input  logic                       prev_valid,
	input  logic                       hit_before,
	input  logic                       ins,
	input  logic [tks_pkg::NK_W-1:0]   nk,
	input  logic [tks_pkg::TOL_W-1:0]  tol,
	output logic                       hit_after,
	output tks_pkg::entry_t            entry_d,
	output tks_pkg::entry_t            entry
);

	logic            below;
	tks_pkg::entry_t entry_q;

	assign entry = entry_q;

	always_comb begin
		logic signed [tks_pkg::KEY_W:0] d;
		logic [tks_pkg::KEY_W:0]        mag;
		below = entry.id < cand.id;
		for (int i = tks_pkg::NUM_KEYS - 1; i >= 0; i--) begin
			d   = {entry.keys[i][tks_pkg::KEY_W-1], entry.keys[i]}
				- {cand.keys[i][tks_pkg::KEY_W-1], cand.keys[i]};
			mag = d[tks_pkg::KEY_W] ? (~d + 1'b1) : d;
			if ((tks_pkg::NK_W'(i) < nk) &&
				(mag > {{(tks_pkg::KEY_W + 1 - tks_pkg::TOL_W){1'b0}}, tol})) begin
				below = $signed(entry.keys[i]) < $signed(cand.keys[i]);
			end
		end
	end

	assign hit_after = hit_before | (valid & below);

	always_comb begin
		entry_d = entry;
		if (ins) begin
			if (hit_before) begin
				entry_d = prev;
			end else if (valid && below) begin
				entry_d = cand;
			end else if (!valid && prev_valid) begin
				entry_d = cand;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### src/tks_drain.sv
module tks_drain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tks_pkg::drain_load_t ld,
	output logic                 busy,
	output logic                 rank_valid,
	input  logic                 rank_stall,
	output tks_pkg::rank_t       rank
);

	logic [tks_pkg::CNT_W-1:0]                       cnt_q;
	logic                                            none_q;
	logic [tks_pkg::MAX_KEPT-1:0][tks_pkg::ID_W-1:0] ids_q;
	logic                                            out_valid_q;
	tks_pkg::rank_t                                  out_q;
	logic                                            adv;
	logic                                            pop;

	assign busy       = cnt_q != '0;
	assign adv        = !out_valid_q || !rank_stall;
	assign pop        = busy && adv;
	assign rank_valid = out_valid_q;
	assign rank       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld.load) begin
				cnt_q <= ld.none ? tks_pkg::CNT_W'(1) : ld.cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (adv) begin
				out_valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			none_q <= ld.none;
			ids_q  <= ld.ids;
		end else if (pop) begin
			for (int i = 0; i < tks_pkg::MAX_KEPT - 1; i++) begin
				ids_q[i] <= ids_q[i+1];
			end
		end
		if (pop) begin
			out_q.ranked_id <= none_q ? '0 : ids_q[0];
			out_q.none_kept <= none_q;
			out_q.run_end   <= cnt_q == tks_pkg::CNT_W'(1);
		end
	end

endmodule

### src/top_k_lexicographic_select_top.sv
// Top-k selector over candidates ranked lexicographically by up to four keys.
// Input channel cand_valid / cand_stall / cand carries one candidate per transfer.
// Output channel rank_valid / rank_stall / rank carries the ranked ids.
// Configuration: cfg_we with cfg_index and cfg_data writes take_count,
// num_keys or tolerance; write only while the block is idle.
// Each accepted eligible candidate is inserted, unless the stop flag is set, by a row
// of compare-and-shift cells, one per kept entry; non-final candidates produce no
// result, so one transfer per cycle is sustained while the output queue is idle.
// A final candidate loads the kept ids into the output queue and clears the
// store. The first result goes through the queue and then the output register; the list
// then leaves at one transfer per cycle while rank_stall is low, and cand_stall stays
// high until the queue has handed its last id to the output register. An empty
// store gives one result with none_kept.
// A stall on rank_stall holds the output register and the queue, and so in
// turn holds the input side after a final candidate.
// Reset clears the store, the stop flag and the output side, and sets
// take_count, num_keys and tolerance to one.
module top_k_lexicographic_select_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tks_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tks_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cand_valid,
	output logic                          cand_stall,
	input  tks_pkg::cand_t                cand,
	output logic                          rank_valid,
	input  logic                          rank_stall,
	output tks_pkg::rank_t                rank
);

	logic [tks_pkg::TAKE_W-1:0] take_count_q;
	logic [tks_pkg::NK_W-1:0]   num_keys_q;
	logic [tks_pkg::TOL_W-1:0]  tolerance_q;
	logic [tks_pkg::CNT_W-1:0]  kept_q;
	logic                       stop_q;

	logic [tks_pkg::TAKE_W-1:0] cap;
	logic [tks_pkg::NK_W-1:0]   nk;
	logic [tks_pkg::CNT_W:0]    grown;
	logic [tks_pkg::CNT_W-1:0]  kept_ins;
	logic [tks_pkg::CNT_W-1:0]  kept_d;
	logic                       take;
	logic                       ins;
	logic                       busy;
	tks_pkg::entry_t            cand_entry;
	tks_pkg::drain_load_t       ld;

	tks_pkg::entry_t [tks_pkg::MAX_KEPT-1:0] entry;
	tks_pkg::entry_t [tks_pkg::MAX_KEPT-1:0] entry_d;
	logic [tks_pkg::MAX_KEPT:0]              hit;
	logic [tks_pkg::MAX_KEPT-1:0]            valid;

	assign cand_stall = busy;
	assign take       = cand_valid && !cand_stall;
	assign ins        = take && cand.eligible && !stop_q;

	assign cap = (take_count_q > tks_pkg::TAKE_W'(tks_pkg::MAX_KEPT))
		? tks_pkg::TAKE_W'(tks_pkg::MAX_KEPT) : take_count_q;
	assign nk  = (num_keys_q > tks_pkg::NK_W'(tks_pkg::NUM_KEYS))
		? tks_pkg::NK_W'(tks_pkg::NUM_KEYS) : num_keys_q;

	assign cand_entry.keys[0] = cand.score_a;
	assign cand_entry.keys[1] = cand.score_b;
	assign cand_entry.keys[2] = cand.score_c;
	assign cand_entry.keys[3] = cand.score_d;
	assign cand_entry.id      = cand.cand_id;

	always_comb begin
		grown    = {1'b0, kept_q} + 1'b1;
		kept_ins = tks_pkg::CNT_W'(grown);
		if (grown > (tks_pkg::CNT_W + 1)'(tks_pkg::MAX_KEPT)) begin
			kept_ins = tks_pkg::CNT_W'(tks_pkg::MAX_KEPT);
		end
		if (kept_ins > tks_pkg::CNT_W'(cap)) begin
			kept_ins = tks_pkg::CNT_W'(cap);
		end
		kept_d = ins ? kept_ins : kept_q;
	end

	assign hit[0] = 1'b0;

	for (genvar g = 0; g < tks_pkg::MAX_KEPT; g++) begin : g_cell
		assign valid[g] = tks_pkg::CNT_W'(g) < kept_q;
		tks_cell u_cell (
			.clk        (clk),
			.cand       (cand_entry),
			.prev       ((g == 0) ? cand_entry : entry[(g == 0) ? 0 : g - 1]),
			.valid      (valid[g]),
			.prev_valid ((g == 0) ? 1'b1 : valid[(g == 0) ? 0 : g - 1]),
			.hit_before (hit[g]),
			.ins        (ins),
			.nk         (nk),
			.tol        (tolerance_q),
			.hit_after  (hit[g+1]),
			.entry_d    (entry_d[g]),
			.entry      (entry[g])
		);
		assign ld.ids[g] = entry_d[g].id;
	end

	assign ld.load = take && cand.final_cand;
	assign ld.none = kept_d == '0;
	assign ld.cnt  = kept_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_count_q <= tks_pkg::TAKE_W'(1);
			num_keys_q   <= tks_pkg::NK_W'(1);
			tolerance_q  <= tks_pkg::TOL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tks_pkg::CFG_TAKE_COUNT: take_count_q <= cfg_data[tks_pkg::TAKE_W-1:0];
				tks_pkg::CFG_NUM_KEYS:   num_keys_q   <= cfg_data[tks_pkg::NK_W-1:0];
				tks_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_data[tks_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			stop_q <= 1'b0;
		end else if (ld.load) begin
			kept_q <= '0;
			stop_q <= 1'b0;
		end else begin
			kept_q <= kept_d;
			if (ins && nk == '0 && grown == {1'b0, cap}) begin
				stop_q <= 1'b1;
			end
		end
	end

	tks_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.busy       (busy),
		.rank_valid (rank_valid),
		.rank_stall (rank_stall),
		.rank       (rank)
	);

endmodule

### verif/top_k_lexicographic_select_top_tb.sv
`timescale 1ns / 100ps

module top_k_lexicographic_select_top_tb;

	typedef enum logic {ROW_CAND, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [tks_pkg::CFG_IDX_W-1:0] idx;
		int unsigned                   val;
		tks_pkg::cand_t                c;
		bit                            typed;
		tks_pkg::rank_t                want;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [tks_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tks_pkg::CFG_W-1:0]     cfg_data;
	logic                          cand_valid;
	logic                          cand_stall;
	tks_pkg::cand_t                cand;
	logic                          rank_valid;
	logic                          rank_stall;
	tks_pkg::rank_t                rank;

	tks_pkg::rank_t                ranked_due[$];
	tks_pkg::rank_t                head_rank;
	row_t                          plan[$];
	int                            errors;
	bit                            steady;

	logic [tks_pkg::TAKE_W-1:0]    take_r;
	logic [tks_pkg::NK_W-1:0]      nkeys_r;
	logic [tks_pkg::TOL_W-1:0]     tol_r;
	tks_pkg::key_t [tks_pkg::NUM_KEYS-1:0] store_keys [tks_pkg::MAX_KEPT];
	logic [tks_pkg::ID_W-1:0]      store_ids [tks_pkg::MAX_KEPT];
	int unsigned                   store_n;
	bit                            halt_taking;

	top_k_lexicographic_select_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.cand       (cand),
		.rank_valid (rank_valid),
		.rank_stall (rank_stall),
		.rank       (rank)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#8000000;
		$display("[top_k_lexicographic_select_top] ERROR");
		$finish;
	end

	function automatic void add_due(input tks_pkg::rank_t r);
		ranked_due.insert(ranked_due.size(), r);
	endfunction

	function automatic void add_row(input row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic bit ranks_lower(input tks_pkg::key_t [tks_pkg::NUM_KEYS-1:0] ak,
			input logic [tks_pkg::ID_W-1:0] aid,
			input tks_pkg::key_t [tks_pkg::NUM_KEYS-1:0] bk,
			input logic [tks_pkg::ID_W-1:0] bid, input int unsigned nk);
		longint diff;
		longint mag;
		for (int i = 0; i < nk; i++) begin
			diff = longint'($signed(ak[i])) - longint'($signed(bk[i]));
			mag = diff < 0 ? -diff : diff;
			if (mag > longint'(tol_r))
				return diff < 0;
		end
		return aid < bid;
	endfunction

	function automatic void rank_candidate(input tks_pkg::cand_t c, input bit emit);
		tks_pkg::key_t [tks_pkg::NUM_KEYS-1:0] k;
		int unsigned cap;
		int unsigned nk;
		int unsigned pos;
		int unsigned grown;
		int unsigned last;
		int unsigned i;
		tks_pkg::rank_t r;
		k[0] = c.score_a;
		k[1] = c.score_b;
		k[2] = c.score_c;
		k[3] = c.score_d;
		cap = take_r > tks_pkg::MAX_KEPT ? tks_pkg::MAX_KEPT : take_r;
		nk = nkeys_r > tks_pkg::NUM_KEYS ? tks_pkg::NUM_KEYS : nkeys_r;
		if (c.eligible && !halt_taking) begin
			pos = store_n;
			for (i = 0; i < store_n; i++) begin
				if (ranks_lower(store_keys[i], store_ids[i], k, c.cand_id, nk)) begin
					pos = i;
					break;
				end
			end
			grown = store_n + 1;
			if (nk == 0 && grown == cap)
				halt_taking = 1'b1;
			if (pos < tks_pkg::MAX_KEPT) begin
				last = store_n < tks_pkg::MAX_KEPT ? store_n : tks_pkg::MAX_KEPT - 1;
				for (i = last; i > pos; i--) begin
					store_keys[i] = store_keys[i-1];
					store_ids[i] = store_ids[i-1];
				end
				store_keys[pos] = k;
				store_ids[pos] = c.cand_id;
			end
			store_n = grown > tks_pkg::MAX_KEPT ? tks_pkg::MAX_KEPT : grown;
			if (store_n > cap)
				store_n = cap;
		end
		if (!c.final_cand)
			return;
		if (emit) begin
			if (store_n == 0) begin
				r = '{ranked_id: '0, none_kept: 1'b1, run_end: 1'b1};
				add_due(r);
			end else begin
				for (i = 0; i < store_n; i++) begin
					r = '{ranked_id: store_ids[i], none_kept: 1'b0, run_end: i + 1 == store_n};
					add_due(r);
				end
			end
		end
		store_n = 0;
		halt_taking = 1'b0;
	endfunction

	function automatic row_t c_row(input logic [tks_pkg::ID_W-1:0] id, input tks_pkg::key_t a,
			input tks_pkg::key_t b, input tks_pkg::key_t c3, input tks_pkg::key_t d,
			input bit el, input bit fi);
		row_t r;
		r.kind = ROW_CAND;
		r.idx = '0;
		r.val = 0;
		r.c = '{cand_id: id, score_a: a, score_b: b, score_c: c3, score_d: d,
			eligible: el, final_cand: fi};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [tks_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned v);
		row_t r;
		r = c_row('0, '0, '0, '0, '0, 1'b0, 1'b0);
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = v;
		return r;
	endfunction

	function automatic row_t typed_row(input row_t r, input tks_pkg::rank_t w);
		row_t t;
		t = r;
		t.typed = 1'b1;
		t.want = w;
		return t;
	endfunction

	function automatic tks_pkg::key_t pick_key(input int mode, input tks_pkg::key_t base);
		case (mode)
			0: return tks_pkg::key_t'($urandom);
			1: return base + tks_pkg::key_t'($urandom_range(0, 6));
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic push_cand(input tks_pkg::cand_t c, input bit typed,
			input tks_pkg::rank_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			cand_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cand = c;
		cand_valid = 1'b1;
		do @(posedge clk); while (cand_stall !== 1'b0);
		rank_candidate(c, !typed);
		if (typed)
			add_due(want);
	endtask

	task automatic settle();
		@(negedge clk);
		cand_valid = 1'b0;
		while (ranked_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tks_pkg::CFG_IDX_W-1:0] idx, input int unsigned v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = tks_pkg::CFG_W'(v);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			tks_pkg::CFG_TAKE_COUNT: take_r = tks_pkg::TAKE_W'(v);
			tks_pkg::CFG_NUM_KEYS:   nkeys_r = tks_pkg::NK_W'(v);
			tks_pkg::CFG_TOLERANCE:  tol_r = tks_pkg::TOL_W'(v);
			default: ;
		endcase
	endtask

	// receiver: stall at random before each transfer, and not at all in steady mode
	initial begin
		int n;
		rank_stall = 1'b0;
		forever begin
			n = steady ? 0 : $urandom_range(0, 17);
			if (n != 0) begin
				@(negedge clk);
				rank_stall = 1'b1;
				repeat (n) @(negedge clk);
				rank_stall = 1'b0;
			end
			do @(posedge clk); while (!(rank_valid === 1'b1 && rank_stall === 1'b0));
		end
	end

	always @(posedge clk) begin
		if (arst_n && rank_valid && !rank_stall) begin
			if (ranked_due.size() == 0) begin
				$error("unexpected rank transfer: ranked_id %h", rank.ranked_id);
				errors++;
			end else begin
				head_rank = ranked_due.pop_front();
				if (rank.ranked_id !== head_rank.ranked_id) begin
					$error("ranked_id: expected %h, got %h", head_rank.ranked_id, rank.ranked_id);
					errors++;
				end
				if (rank.none_kept !== head_rank.none_kept) begin
					$error("none_kept: expected %b, got %b", head_rank.none_kept, rank.none_kept);
					errors++;
				end
				if (rank.run_end !== head_rank.run_end) begin
					$error("run_end: expected %b, got %b", head_rank.run_end, rank.run_end);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t r;
		tks_pkg::cand_t c;
		tks_pkg::rank_t nil;
		int sent;
		int n;
		int mode;
		bit small_ids;
		tks_pkg::key_t base;
		errors = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cand_valid = 1'b0;
		cand = '0;
		take_r = tks_pkg::TAKE_W'(1);
		nkeys_r = tks_pkg::NK_W'(1);
		tol_r = tks_pkg::TOL_W'(1);
		store_n = 0;
		halt_taking = 1'b0;
		nil = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(typed_row(c_row(16'h0005, 0, 0, 0, 0, 1'b0, 1'b1),
			'{ranked_id: '0, none_kept: 1'b1, run_end: 1'b1}));
		add_row(c_row(16'h1234, 32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b0));
		add_row(typed_row(c_row(16'hFFFF, 32'h8000_0000, 0, 0, 0, 1'b1, 1'b1),
			'{ranked_id: 16'h1234, none_kept: 1'b0, run_end: 1'b1}));
		add_row(cfg_row(tks_pkg::CFG_TAKE_COUNT, 8));
		add_row(cfg_row(tks_pkg::CFG_NUM_KEYS, 4));
		add_row(cfg_row(tks_pkg::CFG_TOLERANCE, 0));
		add_row(c_row(16'h0000, 0, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'h0001, 0, 0, 0, 1, 1'b1, 1'b0));
		add_row(c_row(16'h0002, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1, 1'b0));
		add_row(c_row(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1, 1'b0));
		add_row(c_row(16'h00AA, 0, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'h5555, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1'b0, 1'b0));
		add_row(c_row(16'h7777, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1, 1'b1));
		add_row(cfg_row(tks_pkg::CFG_TOLERANCE, 32'h7FFF_FFFF));
		add_row(c_row(16'h0010, 32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'h0020, 32'h8000_0000, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'h0030, 0, 32'h7FFF_FFFF, 0, 0, 1'b1, 1'b1));
		add_row(cfg_row(tks_pkg::CFG_NUM_KEYS, 0));
		add_row(cfg_row(tks_pkg::CFG_TAKE_COUNT, 2));
		add_row(c_row(16'h0003, 5, 5, 5, 5, 1'b1, 1'b0));
		add_row(c_row(16'h0009, 0, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'hFFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b0));
		add_row(c_row(16'h0001, 0, 0, 0, 0, 1'b0, 1'b1));
		add_row(cfg_row(tks_pkg::CFG_TAKE_COUNT, 0));
		add_row(typed_row(c_row(16'h0004, 1, 1, 1, 1, 1'b1, 1'b1),
			'{ranked_id: '0, none_kept: 1'b1, run_end: 1'b1}));
		add_row(cfg_row(tks_pkg::CFG_TAKE_COUNT, 15));
		add_row(cfg_row(tks_pkg::CFG_NUM_KEYS, 7));
		add_row(cfg_row(tks_pkg::CFG_TOLERANCE, 0));
		add_row(c_row(16'h0100, 1, 2, 3, 4, 1'b1, 1'b0));
		add_row(c_row(16'h0200, 1, 2, 3, 5, 1'b1, 1'b0));
		add_row(c_row(16'h0300, 1, 1, 9, 9, 1'b1, 1'b0));
		add_row(cfg_row(tks_pkg::CFG_TAKE_COUNT, 2));
		add_row(c_row(16'h0400, 2, 0, 0, 0, 1'b1, 1'b1));

		foreach (plan[i]) begin
			r = plan[i];
			if (r.kind == ROW_CFG) begin
				settle();
				write_reg(r.idx, r.val);
			end else begin
				push_cand(r.c, r.typed, r.want);
			end
		end

		sent = 0;
		while (sent < 85) begin
			settle();
			if ($urandom_range(0, 1))
				write_reg(tks_pkg::CFG_TAKE_COUNT,
					$urandom_range(0, 3) == 0 ? 15 : $urandom_range(0, 9));
			if ($urandom_range(0, 1))
				write_reg(tks_pkg::CFG_NUM_KEYS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 7)
					: $urandom_range(0, 4));
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: write_reg(tks_pkg::CFG_TOLERANCE, 0);
					1: write_reg(tks_pkg::CFG_TOLERANCE, $urandom_range(0, 8));
					2: write_reg(tks_pkg::CFG_TOLERANCE, 32'h7FFF_FFFF);
					default: write_reg(tks_pkg::CFG_TOLERANCE, $urandom);
				endcase
			end
			steady = $urandom_range(0, 3) == 0;
			mode = $urandom_range(0, 2);
			small_ids = $urandom_range(0, 2) == 0;
			base = tks_pkg::key_t'($urandom);
			n = $urandom_range(0, 3) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 8);
			for (int j = 0; j < n; j++) begin
				c.cand_id = tks_pkg::ID_W'(small_ids ? $urandom_range(0, 7)
					: $urandom_range(0, 16'hFFFF));
				c.score_a = pick_key(mode, base);
				c.score_b = pick_key(mode, base);
				c.score_c = pick_key(mode, base);
				c.score_d = pick_key(mode, base);
				c.eligible = $urandom_range(0, 4) != 0;
				c.final_cand = (j == n - 1) ? $urandom_range(0, 6) != 0 : $urandom_range(0, 30) == 0;
				push_cand(c, 1'b0, nil);
				sent++;
			end
		end
		c.cand_id = tks_pkg::ID_W'($urandom_range(0, 16'hFFFF));
		c.score_a = tks_pkg::key_t'($urandom);
		c.score_b = tks_pkg::key_t'($urandom);
		c.score_c = tks_pkg::key_t'($urandom);
		c.score_d = tks_pkg::key_t'($urandom);
		c.eligible = 1'b1;
		c.final_cand = 1'b1;
		push_cand(c, 1'b0, nil);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[top_k_lexicographic_select_top] OK");
		else
			$display("[top_k_lexicographic_select_top] ERROR");
		$finish;
	end

endmodule

### sim.f
src/tks_pkg.sv
src/tks_cell.sv
src/tks_drain.sv
src/top_k_lexicographic_select_top.sv
verif/top_k_lexicographic_select_top_tb.sv
